[hw/rtl/crd_pkg.sv]
// Shared types and constants for the compressed relocation decoder.
package crd_pkg;

	localparam int CRD_ADDR_WIDTH = 32;
	localparam int CRD_QDEPTH     = 2;

	// header and delta byte bit positions
	localparam int B_TYPE = 7;
	localparam int B_FLAG = 6;
	localparam int B_MORE = 5;
	localparam int B_CONT = 7;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FIRST,
		PH_MORE
	} crd_phase_t;

	typedef enum logic [1:0] {
		K_SINGLE,
		K_RUN,
		K_ERROR
	} crd_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} crd_bstate_t;

	typedef struct packed {
		crd_kind_t   kind;
		logic        clr;
		logic [1:0]  stride_code;
		logic [4:0]  rep;
	} crd_cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} crd_qstat_t;

endpackage

[hw/rtl/crd_in_if.sv]
// Byte stream input channel.
interface crd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_segment;

	modport source (output valid, output data_byte, output new_segment, input ready);
	modport sink (input valid, input data_byte, input new_segment, output ready);
endinterface

[hw/rtl/crd_out_if.sv]
// Decoded address output channel.
interface crd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        is_error;
	logic        last;

	modport source (output valid, output address, output is_error, output last, input ready);
	modport sink (input valid, input address, input is_error, input last, output ready);
endinterface

[hw/rtl/crd_front.sv]
// Record parser: collects header and delta bytes and issues one command per record.
module crd_front #(
	parameter int ADDR_WIDTH = crd_pkg::CRD_ADDR_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	crd_in_if.sink                in_ch,
	input  crd_pkg::crd_qstat_t   qstat,
	output logic                  push,
	output crd_pkg::crd_cmd_t     push_cmd,
	output logic [ADDR_WIDTH-1:0] push_delta
);

	crd_pkg::crd_phase_t   ph_q, ph_n;
	logic [ADDR_WIDTH-1:0] acc_q, acc_n;
	logic [5:0]            pos_q, pos_n;
	logic                  run_q, run_n;
	logic [1:0]            sc_q, sc_n;
	logic [4:0]            rep_q, rep_n;
	logic                  err_q, err_n;
	logic                  clr_q, clr_n;
	logic                  fire;
	logic [7:0]            b;
	logic [ADDR_WIDTH+6:0] grp_wide;
	logic [ADDR_WIDTH-1:0] grp_sh;
	logic                  pos_in_range;
	logic [5:0]            pos_sat;

	assign in_ch.ready = !qstat.full;
	assign fire        = in_ch.valid && in_ch.ready;
	assign b           = in_ch.data_byte;

	assign grp_wide     = (ADDR_WIDTH + 7)'(b[6:0]) << pos_q;
	assign grp_sh       = grp_wide[ADDR_WIDTH-1:0];
	assign pos_in_range = {1'b0, pos_q} < 7'(ADDR_WIDTH);
	assign pos_sat      = (pos_q > 6'd56) ? 6'd63 : pos_q + 6'd7;

	always_comb begin
		ph_n       = ph_q;
		acc_n      = acc_q;
		pos_n      = pos_q;
		run_n      = run_q;
		sc_n       = sc_q;
		rep_n      = rep_q;
		err_n      = err_q;
		clr_n      = clr_q;
		push       = 1'b0;
		push_cmd   = '{kind: crd_pkg::K_SINGLE, clr: 1'b0, stride_code: sc_q, rep: rep_q};
		push_delta = '0;
		if (fire) begin
			if (in_ch.new_segment) begin
				err_n = 1'b0;
				ph_n  = crd_pkg::PH_HEADER;
				acc_n = '0;
				pos_n = '0;
				clr_n = 1'b1;
			end
			// after an error, bytes are dropped until the next segment
			if (!err_n) begin
				case (ph_n)
					crd_pkg::PH_HEADER: begin
						if (!b[crd_pkg::B_TYPE]) begin
							if (!b[crd_pkg::B_FLAG]) begin
								err_n         = 1'b1;
								push          = 1'b1;
								push_cmd.kind = crd_pkg::K_ERROR;
							end else begin
								run_n = 1'b0;
								acc_n = ADDR_WIDTH'(b[4:0]);
								pos_n = 6'd5;
								if (b[crd_pkg::B_MORE]) begin
									ph_n = crd_pkg::PH_MORE;
								end else begin
									push          = 1'b1;
									push_cmd.kind = crd_pkg::K_SINGLE;
								end
							end
						end else begin
							run_n = 1'b1;
							sc_n  = b[6:5];
							rep_n = b[4:0];
							ph_n  = crd_pkg::PH_FIRST;
						end
					end
					crd_pkg::PH_FIRST, crd_pkg::PH_MORE: begin
						if (ph_n == crd_pkg::PH_FIRST) begin
							acc_n = ADDR_WIDTH'(b[6:0]);
							pos_n = 6'd7;
						end else begin
							if (pos_in_range) begin
								acc_n = acc_q | grp_sh;
							end
							pos_n = pos_sat;
						end
						if (b[crd_pkg::B_CONT]) begin
							ph_n = crd_pkg::PH_MORE;
						end else begin
							push          = 1'b1;
							push_cmd.kind = run_n ? crd_pkg::K_RUN : crd_pkg::K_SINGLE;
						end
					end
					default: begin
						ph_n = crd_pkg::PH_HEADER;
					end
				endcase
			end
			if (push) begin
				push_cmd.clr         = clr_n;
				push_cmd.stride_code = sc_n;
				push_cmd.rep         = rep_n;
				push_delta           = acc_n;
				acc_n                = '0;
				pos_n                = '0;
				ph_n                 = crd_pkg::PH_HEADER;
				clr_n                = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= crd_pkg::PH_HEADER;
			acc_q <= '0;
			pos_q <= '0;
			run_q <= 1'b0;
			sc_q  <= 2'd0;
			rep_q <= 5'd0;
			err_q <= 1'b0;
			clr_q <= 1'b0;
		end else begin
			ph_q  <= ph_n;
			acc_q <= acc_n;
			pos_q <= pos_n;
			run_q <= run_n;
			sc_q  <= sc_n;
			rep_q <= rep_n;
			err_q <= err_n;
			clr_q <= clr_n;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("command pushed into full queue");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && !(fire && in_ch.new_segment)) |-> !push)
		else $error("command issued while error is latched");

endmodule

[hw/rtl/crd_fifo.sv]
// Small flop-based command queue between parser and address generator.
module crd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = crd_pkg::CRD_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   wdata,
	input  logic               pop,
	output logic [WIDTH-1:0]   rdata,
	output crd_pkg::crd_qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign stat.full      = cnt_q == CW'(DEPTH);
	assign stat.not_empty = cnt_q != '0;
	assign rdata          = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/crd_back.sv]
// Address generator: applies commands to the running address and emits result words.
module crd_back #(
	parameter int ADDR_WIDTH = crd_pkg::CRD_ADDR_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crd_pkg::crd_qstat_t   qstat,
	input  crd_pkg::crd_cmd_t     cmd,
	input  logic [ADDR_WIDTH-1:0] delta,
	output logic                  pop,
	crd_out_if.source             out_ch
);

	crd_pkg::crd_bstate_t  st_q, st_n;
	logic [ADDR_WIDTH-1:0] ra_q, ra_d;
	logic [ADDR_WIDTH-1:0] stride_q, stride_d;
	logic [5:0]            cnt_q, cnt_d;
	logic                  ov_q;
	logic [ADDR_WIDTH-1:0] oa_q, oa_d;
	logic                  oe_q, oe_d;
	logic                  ol_q, ol_d;
	logic                  load;
	logic                  step;
	logic [ADDR_WIDTH-1:0] base;
	logic [ADDR_WIDTH-1:0] sum;
	logic [ADDR_WIDTH-1:0] nxt;
	logic [ADDR_WIDTH+31:0] oa_ext;

	assign load = !ov_q || out_ch.ready;
	assign base = cmd.clr ? '0 : ra_q;
	assign sum  = base + delta;
	assign nxt  = ra_q + stride_q;

	// next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			crd_pkg::BK_IDLE: begin
				if (qstat.not_empty && load && cmd.kind == crd_pkg::K_RUN) begin
					st_n = crd_pkg::BK_RUN;
				end
			end
			crd_pkg::BK_RUN: begin
				if (load && cnt_q == 6'd1) begin
					st_n = crd_pkg::BK_IDLE;
				end
			end
			default: st_n = crd_pkg::BK_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		pop      = 1'b0;
		step     = 1'b0;
		ra_d     = ra_q;
		stride_d = stride_q;
		cnt_d    = cnt_q;
		oa_d     = oa_q;
		oe_d     = 1'b0;
		ol_d     = 1'b1;
		case (st_q)
			crd_pkg::BK_IDLE: begin
				if (qstat.not_empty && load) begin
					pop  = 1'b1;
					step = 1'b1;
					case (cmd.kind)
						crd_pkg::K_ERROR: begin
							oa_d = base;
							oe_d = 1'b1;
							ra_d = base;
						end
						crd_pkg::K_RUN: begin
							oa_d     = sum;
							ol_d     = 1'b0;
							ra_d     = sum;
							stride_d = ADDR_WIDTH'({3'(cmd.stride_code) + 3'd1, 2'b00});
							cnt_d    = 6'(cmd.rep) + 6'd1;
						end
						default: begin
							oa_d = sum;
							ra_d = sum;
						end
					endcase
				end
			end
			crd_pkg::BK_RUN: begin
				if (load) begin
					step  = 1'b1;
					oa_d  = nxt;
					ra_d  = nxt;
					ol_d  = cnt_q == 6'd1;
					cnt_d = cnt_q - 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= crd_pkg::BK_IDLE;
			ra_q  <= '0;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q  <= st_n;
			ra_q  <= ra_d;
			cnt_q <= cnt_d;
			if (load) begin
				ov_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		stride_q <= stride_d;
		if (step) begin
			oa_q <= oa_d;
			oe_q <= oe_d;
			ol_q <= ol_d;
		end
	end

	assign oa_ext          = {32'd0, oa_q};
	assign out_ch.valid    = ov_q;
	assign out_ch.address  = oa_ext[31:0];
	assign out_ch.is_error = oe_q;
	assign out_ch.last     = ol_q;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oe_q) |-> ol_q)
		else $error("error word without last");

	a_no_pop_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == crd_pkg::BK_RUN) |-> !pop)
		else $error("queue popped during run expansion");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == crd_pkg::BK_RUN && load && cnt_q == 6'd1) |=> (st_q == crd_pkg::BK_IDLE && ol_q))
		else $error("run did not end on its last word");

	a_run_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == crd_pkg::BK_RUN) |-> (cnt_q != 6'd0))
		else $error("run active with zero count");

endmodule

[hw/rtl/compressed_reloc_decoder_top.sv]
// Compressed relocation decoder top level: parser, command queue, address generator.
//
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | data_byte[7:0], new_segment
//  out_ch   | out | valid/ready  | address[31:0], is_error, last
//
// One byte per cycle is taken while the command queue has room; header and delta
// bytes that finish no record give no output.
// A finished record becomes one queued command; a single or error record gives one
// word, a run record with repeat field r gives r+2 words, one per cycle while out_ch
// is ready, set by the address generator's single stride adder.
// The parser keeps taking bytes while a run expands until the two-entry queue fills.
// arst_n clears all control state at once; no clearing pass.
module compressed_reloc_decoder_top #(
	parameter int ADDR_WIDTH = crd_pkg::CRD_ADDR_WIDTH,
	parameter int QDEPTH     = crd_pkg::CRD_QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	crd_in_if.sink    in_ch,
	crd_out_if.source out_ch
);

	localparam int QW = $bits(crd_pkg::crd_cmd_t) + ADDR_WIDTH;

	crd_pkg::crd_qstat_t   qstat;
	logic                  push;
	logic                  pop;
	crd_pkg::crd_cmd_t     push_cmd;
	logic [ADDR_WIDTH-1:0] push_delta;
	crd_pkg::crd_cmd_t     head_cmd;
	logic [ADDR_WIDTH-1:0] head_delta;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;

	crd_front #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.qstat     (qstat),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_delta(push_delta)
	);

	assign q_wdata = {push_cmd, push_delta};

	crd_fifo #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.pop   (pop),
		.rdata (q_rdata),
		.stat  (qstat)
	);

	assign head_cmd   = crd_pkg::crd_cmd_t'(q_rdata[QW-1:ADDR_WIDTH]);
	assign head_delta = q_rdata[ADDR_WIDTH-1:0];

	crd_back #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.cmd   (head_cmd),
		.delta (head_delta),
		.pop   (pop),
		.out_ch(out_ch)
	);

endmodule
